FILE: sv/amis_pkg.sv
// ----------------------------------------------------------------------------
// amis_pkg
// Shared types and codes for the array machine instruction step block.
// ----------------------------------------------------------------------------
package amis_pkg;

    localparam int REG_COUNT = 8;
    localparam int RW        = $clog2(REG_COUNT);

    // Host request codes.
    typedef enum logic [1:0] {
        HOP_START = 2'd0,
        HOP_LOAD  = 2'd1,
        HOP_STEP  = 2'd2
    } hop_t;

    // Machine opcodes.
    typedef enum logic [3:0] {
        OP_CMOV    = 4'd0,
        OP_INDEX   = 4'd1,
        OP_AMEND   = 4'd2,
        OP_ADD     = 4'd3,
        OP_MUL     = 4'd4,
        OP_DIV     = 4'd5,
        OP_NAND    = 4'd6,
        OP_HALT    = 4'd7,
        OP_ALLOC   = 4'd8,
        OP_ABANDON = 4'd9,
        OP_OUT     = 4'd10,
        OP_IN      = 4'd11,
        OP_LOADP   = 4'd12,
        OP_ORTHO   = 4'd13
    } opc_t;

    typedef enum logic [3:0] {
        STAT_OK           = 4'd0,
        STAT_HALT         = 4'd1,
        STAT_BAD_OPCODE   = 4'd2,
        STAT_BAD_ARRAY    = 4'd3,
        STAT_BAD_OFFSET   = 4'd4,
        STAT_DIV_ZERO     = 4'd5,
        STAT_OUT_RANGE    = 4'd6,
        STAT_ALLOC_FAIL   = 4'd7,
        STAT_ABANDON_ZERO = 4'd8
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSN,
        S_REG,
        S_LEN,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_SCAN,
        S_ZERO,
        S_CPRD,
        S_CPWR
    } state_t;

endpackage

FILE: sv/amis_div.sv
// ----------------------------------------------------------------------------
// amis_div
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amis_div
    import amis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            // A borrow out of the subtract means the divisor did not fit.
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/array_machine_instruction_step.sv
// ----------------------------------------------------------------------------
// array_machine_instruction_step
// 32-bit universal machine that executes one instruction per request.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. op 0
// starts a program with length word, op 1 writes program word addr, op 2
// fetches and executes one instruction, offering in_byte / in_eof to IN.
// Each request produces exactly one result, shown for one cycle with done
// high; the receiver cannot stall, and busy is low while done is high, so
// a new request may be taken in that same cycle.
// done comes in the cycle after the request for op 0, op 1, an unused
// op and a step while stopped or out of range. A plain instruction
// passes fetch read, register read and execute; a load adds S_LEN and
// S_LOAD, a multiply S_MUL and an array write S_LEN. Division waits
// on the bit-serial divider. Allocation scans the slots one per cycle
// and then clears every word of the new slot, one per cycle; load
// program copies the whole source slot word by word, reading in S_CPRD
// and writing in S_CPWR, through the single array memory. Registers,
// array words and slot lengths sit in synchronous memories; register
// and slot validity bits are flip-flops. Reset clears register validity,
// ip, slot ownership and the stop flag at once, with no clearing pass.
// ----------------------------------------------------------------------------
module array_machine_instruction_step
    import amis_pkg::*;
#(
    parameter int SLOT_WORDS  = 4096,
    parameter int ARRAY_SLOTS = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [11:0] addr,
    input  logic [31:0] word,
    input  logic [7:0]  in_byte,
    input  logic        in_eof,
    output logic        done,
    output logic [3:0]  status,
    output logic        out_valid,
    output logic [7:0]  out_char,
    output logic        in_taken,
    output logic        stopped
);

    localparam int SW  = $clog2(SLOT_WORDS);
    localparam int SLW = $clog2(ARRAY_SLOTS);
    localparam int LW  = $clog2(SLOT_WORDS + 1);
    localparam int AW  = SLW + SW;

    localparam logic [LW-1:0]  LEN_MAX   = LW'(SLOT_WORDS);
    localparam logic [SLW-1:0] SLOT_LAST = SLW'(ARRAY_SLOTS - 1);

    state_t state_reg, state_next;

    logic [31:0]            insn_reg, insn_next;
    logic [31:0]            ip_reg, ip_next;
    logic [LW-1:0]          len0_reg, len0_next;
    logic                   stop_reg, stop_next;
    logic [ARRAY_SLOTS-1:0] in_use_reg, in_use_next;
    logic [REG_COUNT-1:0]   vld_reg, vld_next;
    logic [31:0]            x_reg, x_next;
    logic [31:0]            y_reg, y_next;
    logic [31:0]            mul_reg, mul_next;
    logic [LW-1:0]          cnt_reg, cnt_next;
    logic [LW-1:0]          lenc_reg, lenc_next;
    logic [SLW-1:0]         scan_reg, scan_next;
    logic [SLW-1:0]         slot_reg, slot_next;
    logic [7:0]             inb_reg, inb_next;
    logic                   eof_reg, eof_next;
    logic                   done_reg, done_next;
    stat_t                  status_reg, status_next;
    logic                   outv_reg, outv_next;
    logic [7:0]             outc_reg, outc_next;
    logic                   taken_reg, taken_next;

    // Array memory.
    logic [31:0]   arr_mem [0:(1 << AW) - 1];
    logic          arr_we;
    logic [AW-1:0] arr_waddr, arr_raddr;
    logic [31:0]   arr_wdata;
    logic [31:0]   arr_rd_reg;

    // Register file memory, two read ports.
    logic [31:0]   rf_mem [0:REG_COUNT-1];
    logic          rf_we;
    logic [RW-1:0] rf_waddr, rdx_addr, rdy_addr;
    logic [31:0]   rf_wdata;
    logic [31:0]   rdx_reg, rdy_reg;
    logic          rvx_reg, rvy_reg;

    // Slot length memory.
    logic [LW-1:0]  len_mem [0:ARRAY_SLOTS-1];
    logic           len_we;
    logic [SLW-1:0] len_waddr, len_raddr;
    logic [LW-1:0]  len_wdata;
    logic [LW-1:0]  len_q_reg;

    logic        div_start, div_done;
    logic [31:0] div_quo;

    logic          accept;
    logic          fetch_ok;
    opc_t          opc, nopc;
    logic [RW-1:0] fa, fb, fc;
    logic [31:0]   rx, ry;
    logic          x_ok, y_ok, off_ok, size_ok;
    logic          scan_free, zero_end, copy_end;
    logic          fin;
    stat_t         fin_st;
    logic [31:0]   load_off;
    logic [LW-1:0] start_len;

    assign accept   = start && !busy;
    assign fetch_ok = ip_reg < 32'(len0_reg);
    assign opc      = opc_t'(insn_reg[31:28]);
    assign nopc     = opc_t'(arr_rd_reg[31:28]);
    assign fa       = insn_reg[8:6];
    assign fb       = insn_reg[5:3];
    assign fc       = insn_reg[2:0];
    // An unwritten register reads as zero.
    assign rx       = rvx_reg ? rdx_reg : 32'd0;
    assign ry       = rvy_reg ? rdy_reg : 32'd0;
    assign x_ok     = (rx < 32'(ARRAY_SLOTS)) && in_use_reg[rx[SLW-1:0]];
    assign y_ok     = (ry < 32'(ARRAY_SLOTS)) && in_use_reg[ry[SLW-1:0]];
    assign off_ok   = y_reg < 32'(len_q_reg);
    assign size_ok  = ry <= 32'(SLOT_WORDS);
    assign scan_free = !in_use_reg[scan_reg];
    // Allocation clears and load program copies the whole slot.
    assign zero_end = cnt_reg == LEN_MAX;
    assign copy_end = cnt_reg == LEN_MAX;
    assign load_off = 32'(addr);
    assign start_len = (word > 32'(SLOT_WORDS)) ? LEN_MAX : word[LW-1:0];

    amis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rx),
        .divisor  (ry),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && op == HOP_STEP && !stop_reg && fetch_ok)
                    state_next = S_INSN;
            end
            S_INSN:
                state_next = S_REG;
            S_REG:
            begin
                case (opc)
                    OP_INDEX, OP_AMEND: state_next = x_ok ? S_LEN : S_IDLE;
                    OP_MUL:             state_next = S_MUL;
                    OP_DIV:             state_next = (ry != 32'd0) ? S_DIV : S_IDLE;
                    OP_ALLOC:           state_next = size_ok ? S_SCAN : S_IDLE;
                    OP_LOADP:
                        state_next = (rx != 32'd0 && x_ok) ? S_LEN : S_IDLE;
                    default:            state_next = S_IDLE;
                endcase
            end
            S_LEN:
            begin
                case (opc)
                    OP_INDEX: state_next = off_ok ? S_LOAD : S_IDLE;
                    OP_AMEND: state_next = S_IDLE;
                    default:  state_next = S_CPRD;
                endcase
            end
            S_LOAD, S_MUL:
                state_next = S_IDLE;
            S_DIV:
                state_next = div_done ? S_IDLE : S_DIV;
            S_SCAN:
            begin
                if (scan_free)
                    state_next = S_ZERO;
                else if (scan_reg == SLOT_LAST)
                    state_next = S_IDLE;
            end
            S_ZERO:
                state_next = zero_end ? S_IDLE : S_ZERO;
            S_CPRD:
                state_next = copy_end ? S_IDLE : S_CPWR;
            S_CPWR:
                state_next = S_CPRD;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        insn_next   = insn_reg;
        ip_next     = ip_reg;
        len0_next   = len0_reg;
        stop_next   = stop_reg;
        in_use_next = in_use_reg;
        vld_next    = vld_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        mul_next    = mul_reg;
        cnt_next    = cnt_reg;
        lenc_next   = lenc_reg;
        scan_next   = scan_reg;
        slot_next   = slot_reg;
        inb_next    = inb_reg;
        eof_next    = eof_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        outv_next   = 1'b0;
        outc_next   = 8'd0;
        taken_next  = 1'b0;
        fin         = 1'b0;
        fin_st      = STAT_OK;
        arr_we      = 1'b0;
        arr_waddr   = '0;
        arr_wdata   = '0;
        arr_raddr   = {SLW'(0), ip_reg[SW-1:0]};
        rf_we       = 1'b0;
        rf_waddr    = fa;
        rf_wdata    = '0;
        rdx_addr    = fb;
        rdy_addr    = fc;
        len_we      = 1'b0;
        len_waddr   = '0;
        len_wdata   = '0;
        len_raddr   = rx[SLW-1:0];
        div_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    inb_next = in_byte;
                    eof_next = in_eof;
                    case (op)
                        HOP_START:
                        begin
                            vld_next    = '0;
                            ip_next     = '0;
                            in_use_next = '0;
                            in_use_next[0] = 1'b1;
                            len0_next   = start_len;
                            len_we      = 1'b1;
                            len_wdata   = start_len;
                            stop_next   = 1'b0;
                            fin         = 1'b1;
                        end
                        HOP_LOAD:
                        begin
                            if (load_off < 32'(SLOT_WORDS))
                            begin
                                arr_we    = 1'b1;
                                arr_waddr = {SLW'(0), load_off[SW-1:0]};
                                arr_wdata = word;
                            end
                            fin = 1'b1;
                        end
                        HOP_STEP:
                        begin
                            // The fetch read is already on the array port.
                            if (stop_reg)
                                fin = 1'b1;
                            else if (!fetch_ok)
                            begin
                                fin    = 1'b1;
                                fin_st = STAT_BAD_OFFSET;
                            end
                        end
                        default:
                            fin = 1'b1;
                    endcase
                end
            end
            S_INSN:
            begin
                insn_next = arr_rd_reg;
                ip_next   = ip_reg + 32'd1;
                if (nopc == OP_AMEND)
                begin
                    rdx_addr = arr_rd_reg[8:6];
                    rdy_addr = arr_rd_reg[5:3];
                end
                else
                begin
                    rdx_addr = arr_rd_reg[5:3];
                    rdy_addr = arr_rd_reg[2:0];
                end
            end
            S_REG:
            begin
                x_next = rx;
                y_next = ry;
                case (opc)
                    OP_CMOV:
                    begin
                        if (ry != 32'd0)
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = rx;
                        end
                        fin = 1'b1;
                    end
                    OP_INDEX:
                    begin
                        if (!x_ok)
                        begin
                            fin    = 1'b1;
                            fin_st = STAT_BAD_ARRAY;
                        end
                    end
                    OP_AMEND:
                    begin
                        // Fetch the value register for the write in S_LEN.
                        rdx_addr = fc;
                        if (!x_ok)
                        begin
                            fin    = 1'b1;
                            fin_st = STAT_BAD_ARRAY;
                        end
                    end
                    OP_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = rx + ry;
                        fin      = 1'b1;
                    end
                    OP_MUL:
                        mul_next = rx * ry;
                    OP_DIV:
                    begin
                        if (ry == 32'd0)
                        begin
                            fin    = 1'b1;
                            fin_st = STAT_DIV_ZERO;
                        end
                        else
                            div_start = 1'b1;
                    end
                    OP_NAND:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = ~(rx & ry);
                        fin      = 1'b1;
                    end
                    OP_HALT:
                    begin
                        fin    = 1'b1;
                        fin_st = STAT_HALT;
                    end
                    OP_ALLOC:
                    begin
                        if (!size_ok)
                        begin
                            fin    = 1'b1;
                            fin_st = STAT_ALLOC_FAIL;
                        end
                        else
                            scan_next = SLW'(1);
                    end
                    OP_ABANDON:
                    begin
                        fin = 1'b1;
                        if (ry == 32'd0)
                            fin_st = STAT_ABANDON_ZERO;
                        else if (!y_ok)
                            fin_st = STAT_BAD_ARRAY;
                        else
                            in_use_next[ry[SLW-1:0]] = 1'b0;
                    end
                    OP_OUT:
                    begin
                        fin = 1'b1;
                        if (ry > 32'd255)
                            fin_st = STAT_OUT_RANGE;
                        else
                        begin
                            outv_next = 1'b1;
                            outc_next = ry[7:0];
                        end
                    end
                    OP_IN:
                    begin
                        rf_we      = 1'b1;
                        rf_waddr   = fc;
                        rf_wdata   = eof_reg ? 32'hFFFF_FFFF : {24'd0, inb_reg};
                        taken_next = 1'b1;
                        fin        = 1'b1;
                    end
                    OP_LOADP:
                    begin
                        if (rx == 32'd0)
                        begin
                            ip_next = ry;
                            fin     = 1'b1;
                        end
                        else if (!x_ok)
                        begin
                            fin    = 1'b1;
                            fin_st = STAT_BAD_ARRAY;
                        end
                    end
                    OP_ORTHO:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = insn_reg[27:25];
                        rf_wdata = {7'd0, insn_reg[24:0]};
                        fin      = 1'b1;
                    end
                    default:
                    begin
                        fin    = 1'b1;
                        fin_st = STAT_BAD_OPCODE;
                    end
                endcase
            end
            S_LEN:
            begin
                case (opc)
                    OP_INDEX:
                    begin
                        if (!off_ok)
                        begin
                            fin    = 1'b1;
                            fin_st = STAT_BAD_OFFSET;
                        end
                        else
                            arr_raddr = {x_reg[SLW-1:0], y_reg[SW-1:0]};
                    end
                    OP_AMEND:
                    begin
                        fin = 1'b1;
                        if (!off_ok)
                            fin_st = STAT_BAD_OFFSET;
                        else
                        begin
                            arr_we    = 1'b1;
                            arr_waddr = {x_reg[SLW-1:0], y_reg[SW-1:0]};
                            arr_wdata = rx;
                        end
                    end
                    default:
                    begin
                        lenc_next = len_q_reg;
                        cnt_next  = '0;
                    end
                endcase
            end
            S_LOAD:
            begin
                rf_we    = 1'b1;
                rf_wdata = arr_rd_reg;
                fin      = 1'b1;
            end
            S_MUL:
            begin
                rf_we    = 1'b1;
                rf_wdata = mul_reg;
                fin      = 1'b1;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rf_we    = 1'b1;
                    rf_wdata = div_quo;
                    fin      = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (scan_free)
                begin
                    slot_next = scan_reg;
                    cnt_next  = '0;
                end
                else if (scan_reg == SLOT_LAST)
                begin
                    fin    = 1'b1;
                    fin_st = STAT_ALLOC_FAIL;
                end
                else
                    scan_next = scan_reg + SLW'(1);
            end
            S_ZERO:
            begin
                if (zero_end)
                begin
                    in_use_next[slot_reg] = 1'b1;
                    len_we    = 1'b1;
                    len_waddr = slot_reg;
                    len_wdata = y_reg[LW-1:0];
                    rf_we     = 1'b1;
                    rf_waddr  = fb;
                    rf_wdata  = 32'(slot_reg);
                    fin       = 1'b1;
                end
                else
                begin
                    arr_we    = 1'b1;
                    arr_waddr = {slot_reg, cnt_reg[SW-1:0]};
                    cnt_next  = cnt_reg + LW'(1);
                end
            end
            S_CPRD:
            begin
                if (copy_end)
                begin
                    len0_next = lenc_reg;
                    len_we    = 1'b1;
                    len_wdata = lenc_reg;
                    ip_next   = y_reg;
                    fin       = 1'b1;
                end
                else
                    arr_raddr = {x_reg[SLW-1:0], cnt_reg[SW-1:0]};
            end
            S_CPWR:
            begin
                arr_we    = 1'b1;
                arr_waddr = {SLW'(0), cnt_reg[SW-1:0]};
                arr_wdata = arr_rd_reg;
                cnt_next  = cnt_reg + LW'(1);
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        if (rf_we)
            vld_next[rf_waddr] = 1'b1;

        if (fin)
        begin
            done_next   = 1'b1;
            status_next = fin_st;
            if (fin_st != STAT_OK)
                stop_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ip_reg     <= '0;
            len0_reg   <= '0;
            stop_reg   <= 1'b0;
            in_use_reg <= '0;
            vld_reg    <= '0;
            rvx_reg    <= 1'b0;
            rvy_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ip_reg     <= ip_next;
            len0_reg   <= len0_next;
            stop_reg   <= stop_next;
            in_use_reg <= in_use_next;
            vld_reg    <= vld_next;
            rvx_reg    <= vld_reg[rdx_addr];
            rvy_reg    <= vld_reg[rdy_addr];
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        insn_reg   <= insn_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        mul_reg    <= mul_next;
        cnt_reg    <= cnt_next;
        lenc_reg   <= lenc_next;
        scan_reg   <= scan_next;
        slot_reg   <= slot_next;
        inb_reg    <= inb_next;
        eof_reg    <= eof_next;
        status_reg <= status_next;
        outv_reg   <= outv_next;
        outc_reg   <= outc_next;
        taken_reg  <= taken_next;
    end

    always_ff @(posedge clk)
    begin
        if (arr_we)
            arr_mem[arr_waddr] <= arr_wdata;
        arr_rd_reg <= arr_mem[arr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_waddr] <= rf_wdata;
        rdx_reg <= rf_mem[rdx_addr];
        rdy_reg <= rf_mem[rdy_addr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[len_waddr] <= len_wdata;
        len_q_reg <= len_mem[len_raddr];
    end

    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_valid = outv_reg;
    assign out_char  = outc_reg;
    assign in_taken  = taken_reg;
    assign stopped   = stop_reg;

endmodule

FILE: sv/amis_chk.sv
// ----------------------------------------------------------------------------
// amis_chk
// Port-level checks for the array machine instruction step block.
// ----------------------------------------------------------------------------
module amis_chk
    import amis_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] status,
    input logic       out_valid,
    input logic       in_taken,
    input logic       stopped
);

    // A result always leaves the block ready for the next request.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted request either finishes at once or keeps the block busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request dropped");

    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> stopped)
        else $error("fault without stop");

    a_out_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_valid || in_taken)) |-> (status == STAT_OK))
        else $error("side effect on faulted step");

    a_flags_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!out_valid && !in_taken))
        else $error("flags outside result cycle");

endmodule

bind array_machine_instruction_step amis_chk u_amis_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .out_valid (out_valid),
    .in_taken  (in_taken),
    .stopped   (stopped)
);
